### hdl/aicp_pkg.sv
// Shared types, codes and lookup functions of the animated image container parser.
package aicp_pkg;

  typedef enum logic [27:0] {
    PH_HDR_ID       = 28'h0000001,
    PH_HDR_LEN      = 28'h0000002,
    PH_CAFF_MAGIC   = 28'h0000004,
    PH_HDR_SIZE     = 28'h0000008,
    PH_NUM_ANIM     = 28'h0000010,
    PH_CRED_ID      = 28'h0000020,
    PH_CRED_LEN     = 28'h0000040,
    PH_YEAR         = 28'h0000080,
    PH_MONTH        = 28'h0000100,
    PH_DAY          = 28'h0000200,
    PH_HOUR         = 28'h0000400,
    PH_MINUTE       = 28'h0000800,
    PH_CREATOR_SIZE = 28'h0001000,
    PH_CREATOR      = 28'h0002000,
    PH_ANIM_ID      = 28'h0004000,
    PH_ANIM_LEN     = 28'h0008000,
    PH_DURATION     = 28'h0010000,
    PH_CIFF_MAGIC   = 28'h0020000,
    PH_CIFF_HSIZE   = 28'h0040000,
    PH_CONTENT_SIZE = 28'h0080000,
    PH_WIDTH        = 28'h0100000,
    PH_HEIGHT       = 28'h0200000,
    PH_CAPTION      = 28'h0400000,
    PH_TAGS         = 28'h0800000,
    PH_PIXELS       = 28'h1000000,
    PH_SLACK        = 28'h2000000,
    PH_DONE         = 28'h4000000,
    PH_DEAD         = 28'h8000000
  } phase_t;

  localparam logic [4:0] KIND_HDR_LEN       = 5'd0;
  localparam logic [4:0] KIND_HDR_SIZE      = 5'd1;
  localparam logic [4:0] KIND_FRAME_COUNT   = 5'd2;
  localparam logic [4:0] KIND_CRED_LEN      = 5'd3;
  localparam logic [4:0] KIND_YEAR          = 5'd4;
  localparam logic [4:0] KIND_MONTH         = 5'd5;
  localparam logic [4:0] KIND_DAY           = 5'd6;
  localparam logic [4:0] KIND_HOUR          = 5'd7;
  localparam logic [4:0] KIND_MINUTE        = 5'd8;
  localparam logic [4:0] KIND_CREATOR_SIZE  = 5'd9;
  localparam logic [4:0] KIND_CREATOR_CHAR  = 5'd10;
  localparam logic [4:0] KIND_FRAME_LEN     = 5'd11;
  localparam logic [4:0] KIND_DURATION      = 5'd12;
  localparam logic [4:0] KIND_FRAME_HSIZE   = 5'd13;
  localparam logic [4:0] KIND_CONTENT_SIZE  = 5'd14;
  localparam logic [4:0] KIND_WIDTH         = 5'd15;
  localparam logic [4:0] KIND_HEIGHT        = 5'd16;
  localparam logic [4:0] KIND_CAPTION_CHAR  = 5'd17;
  localparam logic [4:0] KIND_TAG_CHAR      = 5'd18;
  localparam logic [4:0] KIND_PIXEL         = 5'd19;
  localparam logic [4:0] KIND_FILE_END      = 5'd20;
  localparam logic [4:0] KIND_ERROR         = 5'd21;

  localparam logic [3:0] ERR_HDR_ID      = 4'd1;
  localparam logic [3:0] ERR_CAFF_MAGIC  = 4'd2;
  localparam logic [3:0] ERR_CRED_ID     = 4'd3;
  localparam logic [3:0] ERR_ANIM_ID     = 4'd4;
  localparam logic [3:0] ERR_CIFF_MAGIC  = 4'd5;
  localparam logic [3:0] ERR_HSIZE_SMALL = 4'd6;
  localparam logic [3:0] ERR_NO_NEWLINE  = 4'd7;
  localparam logic [3:0] ERR_TAG_OPEN    = 4'd8;
  localparam logic [3:0] ERR_BLOCK_OVER  = 4'd9;

  localparam logic [7:0] ID_HEADER  = 8'd1;
  localparam logic [7:0] ID_CREDITS = 8'd2;
  localparam logic [7:0] ID_ANIM    = 8'd3;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [63:0] FIXED_FRAME_HDR = 64'd36;
  localparam logic [63:0] MIN_FRAME_HDR   = 64'd37;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  fcnt;
    logic [63:0] acc;
    logic [63:0] frames;
    logic [63:0] blk;
    logic [63:0] fhl;
    logic [63:0] content;
    logic [17:0] pix;
  } aicp_state_t;

  localparam aicp_state_t ST_RESET = '{phase: PH_HDR_ID, default: '0};

  typedef struct packed {
    logic        valid;
    logic [4:0]  kind;
    logic [63:0] value;
    logic        strend;
    logic        ends;
  } aicp_rec_t;

  // Byte length of a little-endian field phase; zero for other phases.
  function automatic logic [3:0] field_len(input phase_t ph);
    logic [3:0] len;
    unique case (ph)
      PH_HDR_LEN, PH_HDR_SIZE, PH_NUM_ANIM, PH_CRED_LEN, PH_CREATOR_SIZE,
      PH_ANIM_LEN, PH_DURATION, PH_CIFF_HSIZE, PH_CONTENT_SIZE, PH_WIDTH,
      PH_HEIGHT: len = 4'd8;
      PH_YEAR: len = 4'd2;
      PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE: len = 4'd1;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [4:0] field_kind(input phase_t ph);
    logic [4:0] k;
    unique case (ph)
      PH_HDR_LEN:      k = KIND_HDR_LEN;
      PH_HDR_SIZE:     k = KIND_HDR_SIZE;
      PH_NUM_ANIM:     k = KIND_FRAME_COUNT;
      PH_CRED_LEN:     k = KIND_CRED_LEN;
      PH_YEAR:         k = KIND_YEAR;
      PH_MONTH:        k = KIND_MONTH;
      PH_DAY:          k = KIND_DAY;
      PH_HOUR:         k = KIND_HOUR;
      PH_MINUTE:       k = KIND_MINUTE;
      PH_CREATOR_SIZE: k = KIND_CREATOR_SIZE;
      PH_ANIM_LEN:     k = KIND_FRAME_LEN;
      PH_DURATION:     k = KIND_DURATION;
      PH_CIFF_HSIZE:   k = KIND_FRAME_HSIZE;
      PH_CONTENT_SIZE: k = KIND_CONTENT_SIZE;
      PH_WIDTH:        k = KIND_WIDTH;
      PH_HEIGHT:       k = KIND_HEIGHT;
      default:         k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Phase that follows a completed field or magic.
  function automatic phase_t phase_after(input phase_t ph);
    phase_t p;
    unique case (ph)
      PH_HDR_LEN:      p = PH_CAFF_MAGIC;
      PH_CAFF_MAGIC:   p = PH_HDR_SIZE;
      PH_HDR_SIZE:     p = PH_NUM_ANIM;
      PH_NUM_ANIM:     p = PH_CRED_ID;
      PH_CRED_LEN:     p = PH_YEAR;
      PH_YEAR:         p = PH_MONTH;
      PH_MONTH:        p = PH_DAY;
      PH_DAY:          p = PH_HOUR;
      PH_HOUR:         p = PH_MINUTE;
      PH_MINUTE:       p = PH_CREATOR_SIZE;
      PH_CREATOR_SIZE: p = PH_CREATOR;
      PH_ANIM_LEN:     p = PH_DURATION;
      PH_DURATION:     p = PH_CIFF_MAGIC;
      PH_CIFF_MAGIC:   p = PH_CIFF_HSIZE;
      PH_CIFF_HSIZE:   p = PH_CONTENT_SIZE;
      PH_CONTENT_SIZE: p = PH_WIDTH;
      PH_WIDTH:        p = PH_HEIGHT;
      PH_HEIGHT:       p = PH_CAPTION;
      default:         p = PH_DEAD;
    endcase
    return p;
  endfunction

  // Phases whose bytes count against the animation block length.
  function automatic logic in_block(input phase_t ph);
    logic r;
    unique case (ph)
      PH_DURATION, PH_CIFF_MAGIC, PH_CIFF_HSIZE, PH_CONTENT_SIZE, PH_WIDTH,
      PH_HEIGHT, PH_CAPTION, PH_TAGS, PH_PIXELS, PH_SLACK: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Expected magic character: "CAFF" or "CIFF".
  function automatic logic [7:0] magic_char(input logic ciff, input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = "C";
      2'd1:    c = ciff ? "I" : "A";
      default: c = "F";
    endcase
    return c;
  endfunction

endpackage

### hdl/aicp_step.sv
// Per-byte decode: next parser state and the record caused by one byte.
module aicp_step (
  input  aicp_pkg::aicp_state_t cur,
  input  logic [7:0]            data_byte,
  input  logic                  sof,
  output aicp_pkg::aicp_state_t nxt,
  output aicp_pkg::aicp_rec_t   rec
);
  import aicp_pkg::*;

  aicp_state_t s;
  logic [63:0] acc_v;
  logic [63:0] blk_dec;
  logic [63:0] frames_dec;
  logic [63:0] cdec;
  logic [63:0] fdec;
  logic [3:0]  flen;
  logic [1:0]  cnt;
  logic        done;
  logic        ciff;

  always_comb begin
    s          = sof ? ST_RESET : cur;
    nxt        = s;
    rec        = '0;
    done       = 1'b0;
    acc_v      = s.acc;
    acc_v[{s.fcnt, 3'b000} +: 8] = data_byte;
    blk_dec    = s.blk - 64'd1;
    frames_dec = s.frames - 64'd1;
    cdec       = s.content - 64'd1;
    fdec       = s.fhl - 64'd1;
    flen       = field_len(s.phase);
    cnt        = s.pix[17:16];
    ciff       = (s.phase == PH_CIFF_MAGIC);

    if (s.phase == PH_DONE || s.phase == PH_DEAD) begin
      nxt = s;
    end else if (in_block(s.phase) && s.blk == 64'd0) begin
      nxt.phase = PH_DEAD;
      rec = '{valid: 1'b1, kind: KIND_ERROR, value: {60'd0, ERR_BLOCK_OVER}, default: '0};
    end else begin
      if (in_block(s.phase)) nxt.blk = blk_dec;

      if (flen != 4'd0) begin
        if ({1'b0, s.fcnt} + 4'd1 >= flen) begin
          nxt.acc  = '0;
          nxt.fcnt = '0;
          if (s.phase == PH_CIFF_HSIZE && acc_v < MIN_FRAME_HDR) begin
            nxt.phase = PH_DEAD;
            rec = '{valid: 1'b1, kind: KIND_ERROR, value: {60'd0, ERR_HSIZE_SMALL},
                    default: '0};
          end else begin
            rec = '{valid: 1'b1, kind: field_kind(s.phase), value: acc_v, default: '0};
            nxt.phase = phase_after(s.phase);
            unique case (s.phase)
              PH_NUM_ANIM: nxt.frames = acc_v;
              PH_CREATOR_SIZE: begin
                nxt.content = acc_v;
                if (acc_v == 64'd0) begin
                  if (s.frames == 64'd0) begin
                    nxt.phase = PH_DONE;
                    done = 1'b1;
                  end else begin
                    nxt.phase = PH_ANIM_ID;
                  end
                end
              end
              PH_ANIM_LEN:     nxt.blk = acc_v;
              PH_CIFF_HSIZE:   nxt.fhl = acc_v;
              PH_CONTENT_SIZE: nxt.content = acc_v;
              PH_HEIGHT:       nxt.fhl = s.fhl - FIXED_FRAME_HDR;
              default: ;
            endcase
          end
        end else begin
          nxt.acc  = acc_v;
          nxt.fcnt = s.fcnt + 3'd1;
        end
      end else begin
        unique case (s.phase)
          PH_HDR_ID: begin
            if (data_byte != ID_HEADER) begin
              nxt.phase = PH_DEAD;
              rec = '{valid: 1'b1, kind: KIND_ERROR, value: {60'd0, ERR_HDR_ID},
                      default: '0};
            end else begin
              nxt.phase = PH_HDR_LEN;
            end
          end
          PH_CRED_ID: begin
            if (data_byte != ID_CREDITS) begin
              nxt.phase = PH_DEAD;
              rec = '{valid: 1'b1, kind: KIND_ERROR, value: {60'd0, ERR_CRED_ID},
                      default: '0};
            end else begin
              nxt.phase = PH_CRED_LEN;
            end
          end
          PH_ANIM_ID: begin
            if (data_byte != ID_ANIM) begin
              nxt.phase = PH_DEAD;
              rec = '{valid: 1'b1, kind: KIND_ERROR, value: {60'd0, ERR_ANIM_ID},
                      default: '0};
            end else begin
              nxt.phase = PH_ANIM_LEN;
            end
          end
          PH_CAFF_MAGIC, PH_CIFF_MAGIC: begin
            if (data_byte != magic_char(ciff, s.fcnt[1:0])) begin
              nxt.fcnt  = '0;
              nxt.phase = PH_DEAD;
              rec = '{valid: 1'b1, kind: KIND_ERROR,
                      value: {60'd0, ciff ? ERR_CIFF_MAGIC : ERR_CAFF_MAGIC},
                      default: '0};
            end else if (s.fcnt[1:0] == 2'd3) begin
              nxt.fcnt  = '0;
              nxt.phase = phase_after(s.phase);
            end else begin
              nxt.fcnt = s.fcnt + 3'd1;
            end
          end
          PH_CREATOR: begin
            nxt.content = cdec;
            rec = '{valid: 1'b1, kind: KIND_CREATOR_CHAR, value: {56'd0, data_byte},
                    strend: (cdec == 64'd0), default: '0};
            if (cdec == 64'd0) begin
              if (s.frames == 64'd0) begin
                nxt.phase = PH_DONE;
                done = 1'b1;
              end else begin
                nxt.phase = PH_ANIM_ID;
              end
            end
          end
          PH_CAPTION, PH_TAGS: begin
            nxt.fhl = fdec;
            if ((s.phase == PH_CAPTION && data_byte == CHAR_NL) ||
                (s.phase == PH_TAGS && data_byte == CHAR_NUL)) begin
              rec = '{valid: 1'b1,
                      kind: (s.phase == PH_CAPTION) ? KIND_CAPTION_CHAR : KIND_TAG_CHAR,
                      value: {56'd0, data_byte}, strend: 1'b1, default: '0};
              if (fdec == 64'd0) begin
                // start content: pixels, slack bytes, or close the frame body at once
                nxt.pix = '0;
                if (s.content != 64'd0) begin
                  nxt.phase = PH_PIXELS;
                end else if (blk_dec != 64'd0) begin
                  nxt.phase = PH_SLACK;
                end else begin
                  nxt.frames = frames_dec;
                  nxt.phase  = (frames_dec == 64'd0) ? PH_DONE : PH_ANIM_ID;
                  done       = (frames_dec == 64'd0);
                end
              end else begin
                nxt.phase = PH_TAGS;
              end
            end else if (fdec == 64'd0) begin
              nxt.phase = PH_DEAD;
              rec = '{valid: 1'b1, kind: KIND_ERROR,
                      value: {60'd0, (s.phase == PH_CAPTION) ? ERR_NO_NEWLINE : ERR_TAG_OPEN},
                      default: '0};
            end else begin
              rec = '{valid: 1'b1,
                      kind: (s.phase == PH_CAPTION) ? KIND_CAPTION_CHAR : KIND_TAG_CHAR,
                      value: {56'd0, data_byte}, default: '0};
            end
          end
          PH_PIXELS: begin
            nxt.content = cdec;
            if (cnt >= 2'd2) begin
              rec = '{valid: 1'b1, kind: KIND_PIXEL,
                      value: {40'd0, s.pix[15:0], data_byte}, default: '0};
              nxt.pix = '0;
            end else begin
              nxt.pix = {cnt + 2'd1, s.pix[7:0], data_byte};
            end
            if (cdec == 64'd0) begin
              if (blk_dec != 64'd0) begin
                nxt.phase = PH_SLACK;
              end else begin
                nxt.frames = frames_dec;
                nxt.phase  = (frames_dec == 64'd0) ? PH_DONE : PH_ANIM_ID;
                done       = (frames_dec == 64'd0);
              end
            end
          end
          PH_SLACK: begin
            if (blk_dec == 64'd0) begin
              nxt.frames = frames_dec;
              nxt.phase  = (frames_dec == 64'd0) ? PH_DONE : PH_ANIM_ID;
              done       = (frames_dec == 64'd0);
            end
          end
          default: ;
        endcase
      end
    end

    // a completing byte with nothing else to say reports the file end
    if (done && !rec.valid) begin
      rec = '{valid: 1'b1, kind: KIND_FILE_END, default: '0};
    end
    rec.ends = done;
  end

endmodule

### hdl/animated_image_container_parser_top.sv
// Top level of the animated image container parser: stream ports, byte and record registers.
// Takes a container file one byte per beat and gives at most one record per byte: decoded
// little-endian fields, creator/caption/tag characters, packed RGB pixels, a file end or an
// error. Mark the first byte of each file with s_axis_tuser; that restarts parsing and clears
// the dead state left by an error. Each byte is registered, decoded combinationally against the
// full parser state and its record registered, so one byte per clock is accepted sustained
// unless a held record waits for m_axis_tready; the single decode stage, which updates all
// length counters at once, sets that rate. Bytes that yield no record are absorbed silently.
module animated_image_container_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] record_value
  output logic [5:0]  m_axis_tuser,   // [4:0] record_kind, [5] string_end
  output logic        m_axis_tlast    // ends_file
);
  import aicp_pkg::*;

  aicp_state_t state;
  aicp_state_t state_next;
  aicp_rec_t   rec;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_sof;
  logic        out_valid;
  logic [4:0]  out_kind;
  logic [63:0] out_value;
  logic        out_strend;
  logic        out_ends;
  logic        advance;

  aicp_step u_step (
    .cur       (state),
    .data_byte (in_byte),
    .sof       (in_sof),
    .nxt       (state_next),
    .rec       (rec)
  );

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= ST_RESET;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) begin
        state     <= state_next;
        out_valid <= rec.valid;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_sof  <= s_axis_tuser;
    end
    if (advance && rec.valid) begin
      out_kind   <= rec.kind;
      out_value  <= rec.value;
      out_strend <= rec.strend;
      out_ends   <= rec.ends;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = {out_strend, out_kind};
  assign m_axis_tlast  = out_ends;

  a_error_goes_dead: assert property (@(posedge clk) disable iff (rst)
    advance && rec.valid && rec.kind == KIND_ERROR |=> state.phase == PH_DEAD)
    else $error("error record without dead phase");

  a_end_goes_done: assert property (@(posedge clk) disable iff (rst)
    advance && rec.ends |=> state.phase == PH_DONE)
    else $error("file end without done phase");

  a_quiet_after_stop: assert property (@(posedge clk) disable iff (rst)
    advance && !in_sof && (state.phase == PH_DONE || state.phase == PH_DEAD) |-> !rec.valid)
    else $error("record after file end or error");

  a_strend_on_chars: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[5] |->
      (m_axis_tuser[4:0] == KIND_CREATOR_CHAR || m_axis_tuser[4:0] == KIND_CAPTION_CHAR ||
       m_axis_tuser[4:0] == KIND_TAG_CHAR))
    else $error("string end on a non-character record");

  a_pixel_count: assert property (@(posedge clk) disable iff (rst)
    state.pix[17:16] != 2'd3)
    else $error("pixel byte count overflow");

endmodule

### tb/sv/animated_image_container_parser_top_tb.sv
// Testbench for the animated image container parser: byte stream in, checked record stream out.
`timescale 1ns / 1ps

module animated_image_container_parser_top_tb;
  import aicp_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       sof;
    logic       typed;   // expectation written in the table, not predicted
    aicp_rec_t  exp;
  } byte_item_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_MUTATE,
    FLAW_HSIZE,
    FLAW_NO_NL,
    FLAW_TAG_OPEN,
    FLAW_SHORT_BLOCK,
    FLAW_TRUNCATE
  } flaw_t;

  localparam aicp_rec_t NO_REC = '0;
  localparam int RANDOM_BYTES = 400;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;    // [0] start_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // [63:0] record_value
  logic [5:0]  m_axis_tuser;           // [4:0] record_kind, [5] string_end
  logic        m_axis_tlast;           // ends_file

  animated_image_container_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("animated_image_container_parser_top regression: fail");
    $finish;
  end

  // Parser shadow state
  phase_t      pm_phase = PH_HDR_ID;
  logic [3:0]  pm_nbytes = '0;
  logic [63:0] pm_acc = '0;
  logic [63:0] pm_frames = '0;
  logic [63:0] pm_block_left = '0;
  logic [63:0] pm_hdr_left = '0;
  logic [63:0] pm_cont_left = '0;
  logic [1:0]  pm_pix_cnt = '0;
  logic [15:0] pm_pix_rg = '0;
  logic        pm_file_done = 1'b0;

  byte_item_t  stim_q[$];
  aicp_rec_t   rec_q[$];
  byte_item_t  cur_item = '0;
  int          rx_idle_pct = 68;
  int          fail_cnt = 0;
  int          bytes_taken = 0;
  int          files_seen = 0;
  int          recs_checked = 0;
  int          err_recs = 0;
  int          end_recs = 0;
  int          pixel_recs = 0;

  function automatic aicp_rec_t rec(input logic [4:0] kind, input logic [63:0] value);
    return {1'b1, kind, value, 2'b00};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic next_block_or_done();
    if (pm_frames == 0) begin
      pm_phase = PH_DONE;
      pm_file_done = 1'b1;
    end else begin
      pm_phase = PH_ANIM_ID;
    end
  endtask

  task automatic close_block();
    pm_frames = pm_frames - 64'd1;
    next_block_or_done();
  endtask

  task automatic body_complete();
    if (pm_block_left == 0) close_block();
    else pm_phase = PH_SLACK;
  endtask

  task automatic open_content();
    pm_pix_cnt = '0;
    pm_pix_rg = '0;
    if (pm_cont_left == 0) body_complete();
    else pm_phase = PH_PIXELS;
  endtask

  // Advance the shadow parser by one byte and give the record it yields, if any.
  task automatic parse_byte(input logic [7:0] b, input logic sof, output aicp_rec_t r);
    logic [3:0]  flen;
    logic [3:0]  errc;
    logic [4:0]  fkind;
    logic [63:0] v;
    logic [31:0] magic;
    logic [7:0]  mc;
    logic        body;
    logic        caff;
    phase_t      fnext;
    r = NO_REC;
    errc = '0;
    pm_file_done = 1'b0;
    if (sof) begin
      pm_phase = PH_HDR_ID;
      pm_nbytes = '0;
      pm_acc = '0;
      pm_frames = '0;
      pm_block_left = '0;
      pm_hdr_left = '0;
      pm_cont_left = '0;
      pm_pix_cnt = '0;
      pm_pix_rg = '0;
    end
    if (pm_phase != PH_DONE && pm_phase != PH_DEAD) begin
      flen = '0;
      fkind = KIND_ERROR;
      fnext = PH_DEAD;
      body = 1'b0;
      case (pm_phase)
        PH_HDR_LEN:      begin flen = 4'd8; fkind = KIND_HDR_LEN;      fnext = PH_CAFF_MAGIC; end
        PH_HDR_SIZE:     begin flen = 4'd8; fkind = KIND_HDR_SIZE;     fnext = PH_NUM_ANIM; end
        PH_NUM_ANIM:     begin flen = 4'd8; fkind = KIND_FRAME_COUNT;  fnext = PH_CRED_ID; end
        PH_CRED_LEN:     begin flen = 4'd8; fkind = KIND_CRED_LEN;     fnext = PH_YEAR; end
        PH_YEAR:         begin flen = 4'd2; fkind = KIND_YEAR;         fnext = PH_MONTH; end
        PH_MONTH:        begin flen = 4'd1; fkind = KIND_MONTH;        fnext = PH_DAY; end
        PH_DAY:          begin flen = 4'd1; fkind = KIND_DAY;          fnext = PH_HOUR; end
        PH_HOUR:         begin flen = 4'd1; fkind = KIND_HOUR;         fnext = PH_MINUTE; end
        PH_MINUTE:       begin flen = 4'd1; fkind = KIND_MINUTE;       fnext = PH_CREATOR_SIZE; end
        PH_CREATOR_SIZE: begin flen = 4'd8; fkind = KIND_CREATOR_SIZE; fnext = PH_CREATOR; end
        PH_ANIM_LEN:     begin flen = 4'd8; fkind = KIND_FRAME_LEN;    fnext = PH_DURATION; end
        PH_DURATION: begin
          flen = 4'd8; fkind = KIND_DURATION; fnext = PH_CIFF_MAGIC; body = 1'b1;
        end
        PH_CIFF_HSIZE: begin
          flen = 4'd8; fkind = KIND_FRAME_HSIZE; fnext = PH_CONTENT_SIZE; body = 1'b1;
        end
        PH_CONTENT_SIZE: begin
          flen = 4'd8; fkind = KIND_CONTENT_SIZE; fnext = PH_WIDTH; body = 1'b1;
        end
        PH_WIDTH: begin
          flen = 4'd8; fkind = KIND_WIDTH; fnext = PH_HEIGHT; body = 1'b1;
        end
        PH_HEIGHT: begin
          flen = 4'd8; fkind = KIND_HEIGHT; fnext = PH_CAPTION; body = 1'b1;
        end
        PH_CIFF_MAGIC, PH_CAPTION, PH_TAGS, PH_PIXELS, PH_SLACK: body = 1'b1;
        default: ;
      endcase

      if (body && pm_block_left == 0) begin
        errc = ERR_BLOCK_OVER;
      end else begin
        if (body) pm_block_left = pm_block_left - 64'd1;
        if (flen != 0) begin
          pm_acc = pm_acc | ({56'd0, b} << (8 * pm_nbytes[2:0]));
          pm_nbytes = {1'b0, pm_nbytes[2:0]} + 4'd1;
          if (pm_nbytes >= flen) begin
            v = pm_acc;
            pm_acc = '0;
            pm_nbytes = '0;
            if (pm_phase == PH_CIFF_HSIZE && v < MIN_FRAME_HDR) begin
              errc = ERR_HSIZE_SMALL;
            end else begin
              r = rec(fkind, v);
              case (pm_phase)
                PH_NUM_ANIM:     pm_frames = v;
                PH_CREATOR_SIZE: pm_cont_left = v;
                PH_ANIM_LEN:     pm_block_left = v;
                PH_CIFF_HSIZE:   pm_hdr_left = v;
                PH_CONTENT_SIZE: pm_cont_left = v;
                PH_HEIGHT:       pm_hdr_left = pm_hdr_left - FIXED_FRAME_HDR;
                default: ;
              endcase
              pm_phase = fnext;
              // empty creator: the credits block ends on its size field
              if (fnext == PH_CREATOR && v == 0) next_block_or_done();
            end
          end
        end else begin
          case (pm_phase)
            PH_HDR_ID: begin
              if (b != ID_HEADER) errc = ERR_HDR_ID;
              else pm_phase = PH_HDR_LEN;
            end
            PH_CRED_ID: begin
              if (b != ID_CREDITS) errc = ERR_CRED_ID;
              else pm_phase = PH_CRED_LEN;
            end
            PH_ANIM_ID: begin
              if (b != ID_ANIM) errc = ERR_ANIM_ID;
              else pm_phase = PH_ANIM_LEN;
            end
            PH_CAFF_MAGIC, PH_CIFF_MAGIC: begin
              caff = (pm_phase == PH_CAFF_MAGIC);
              magic = caff ? "CAFF" : "CIFF";
              mc = magic[8 * (3 - pm_nbytes[1:0]) +: 8];
              if (b != mc) begin
                pm_nbytes = '0;
                errc = caff ? ERR_CAFF_MAGIC : ERR_CIFF_MAGIC;
              end else if (pm_nbytes[1:0] == 2'd3) begin
                pm_nbytes = '0;
                pm_phase = caff ? PH_HDR_SIZE : PH_CIFF_HSIZE;
              end else begin
                pm_nbytes = {2'b00, pm_nbytes[1:0]} + 4'd1;
              end
            end
            PH_CREATOR: begin
              pm_cont_left = pm_cont_left - 64'd1;
              r = {1'b1, KIND_CREATOR_CHAR, {56'd0, b}, pm_cont_left == 0, 1'b0};
              if (pm_cont_left == 0) next_block_or_done();
            end
            PH_CAPTION: begin
              pm_hdr_left = pm_hdr_left - 64'd1;
              if (b == CHAR_NL) begin
                r = {1'b1, KIND_CAPTION_CHAR, {56'd0, b}, 2'b10};
                if (pm_hdr_left == 0) open_content();
                else pm_phase = PH_TAGS;
              end else if (pm_hdr_left == 0) begin
                errc = ERR_NO_NEWLINE;
              end else begin
                r = rec(KIND_CAPTION_CHAR, {56'd0, b});
              end
            end
            PH_TAGS: begin
              pm_hdr_left = pm_hdr_left - 64'd1;
              if (b == CHAR_NUL) begin
                r = {1'b1, KIND_TAG_CHAR, {56'd0, b}, 2'b10};
                if (pm_hdr_left == 0) open_content();
              end else if (pm_hdr_left == 0) begin
                errc = ERR_TAG_OPEN;
              end else begin
                r = rec(KIND_TAG_CHAR, {56'd0, b});
              end
            end
            PH_PIXELS: begin
              pm_cont_left = pm_cont_left - 64'd1;
              if (pm_pix_cnt >= 2'd2) begin
                r = rec(KIND_PIXEL, {40'd0, pm_pix_rg, b});
                pm_pix_cnt = '0;
                pm_pix_rg = '0;
              end else begin
                pm_pix_cnt = pm_pix_cnt + 2'd1;
                pm_pix_rg = {pm_pix_rg[7:0], b};
              end
              if (pm_cont_left == 0) body_complete();
            end
            PH_SLACK: begin
              if (pm_block_left == 0) close_block();
            end
            default: ;
          endcase
        end
      end

      if (errc != 0) begin
        r = rec(KIND_ERROR, {60'd0, errc});
        pm_phase = PH_DEAD;
      end else if (pm_file_done && !r.valid) begin
        r = rec(KIND_FILE_END, 64'd0);
      end
      r.ends = pm_file_done;
    end
  endtask

  task automatic report_bad(input string what, input aicp_rec_t want, input aicp_rec_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display({"%0t %s: want kind %0d value %h strend %0d ends %0d,",
                " got kind %0d value %h strend %0d ends %0d"},
               $realtime, what, want.kind, want.value, want.strend, want.ends,
               got.kind, got.value, got.strend, got.ends);
  endtask

  // Check record beats, then predict from byte beats taken at the same edge.
  always @(posedge clk) begin : scoreboard
    aicp_rec_t got;
    aicp_rec_t want;
    aicp_rec_t pred;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {1'b1, m_axis_tuser[4:0], m_axis_tdata, m_axis_tuser[5], m_axis_tlast};
        recs_checked++;
        if (got.kind == KIND_ERROR) err_recs++;
        if (got.ends) end_recs++;
        if (got.kind == KIND_PIXEL) pixel_recs++;
        if (rec_q.size() == 0) begin
          report_bad("unexpected record", NO_REC, got);
        end else begin
          want = rec_q.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.strend !== want.strend || got.ends !== want.ends)
            report_bad("record mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tuser, pred);
        if (cur_item.typed) pred = cur_item.exp;
        if (pred.valid) rec_q.insert(rec_q.size(), pred);
        bytes_taken++;
        if (s_axis_tuser) files_seen++;
      end
    end
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

  task automatic add_row(input logic [7:0] b, input logic sof, input logic typed,
                         input aicp_rec_t exp);
    byte_item_t it;
    it = {b, sof, typed, exp};
    stim_q.insert(stim_q.size(), it);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic sof);
    add_row(b, sof, 1'b0, NO_REC);
  endtask

  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) put_byte(v[8 * i +: 8], 1'b0);
  endtask

  task automatic put_text(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) put_byte(t[8 * i +: 8], 1'b0);
  endtask

  // Append one container, mostly well formed, sometimes with a single flaw.
  task automatic add_container();
    flaw_t       flaw;
    int          start;
    int          nfr;
    int          csz;
    int          ntag;
    int          caplen;
    int          ccnt;
    int          slack;
    int          idx;
    int          tag_len[2];
    logic        flawed;
    logic [7:0]  ch;
    logic [63:0] hsz;
    logic [63:0] blen;
    byte_item_t  it;
    start = stim_q.size();
    flaw = ($urandom_range(0, 99) < 60) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
    idx = $urandom_range(0, 9);
    nfr = (idx < 3) ? 0 : (idx < 8) ? 1 : 2;

    put_byte(ID_HEADER, 1'b1);
    put_le(rand64(), 8);
    put_text("CAFF");
    put_le(rand64(), 8);
    put_le(64'(nfr), 8);

    put_byte(ID_CREDITS, 1'b0);
    put_le(rand64(), 8);
    put_le(rand64(), 6);    // year, month, day, hour, minute
    csz = $urandom_range(0, 3);
    put_le(64'(csz), 8);
    repeat (csz) put_byte(8'($urandom), 1'b0);

    for (int f = 0; f < nfr; f++) begin
      flawed = (f == 0);
      caplen = $urandom_range(0, 3);
      ntag = $urandom_range(0, 2);
      if (flawed && flaw == FLAW_NO_NL) ntag = 0;
      if (flawed && flaw == FLAW_TAG_OPEN) ntag = $urandom_range(1, 2);
      hsz = 64'd36 + 64'(caplen) + 64'd1;
      for (int t = 0; t < ntag; t++) begin
        tag_len[t] = $urandom_range(0, 2);
        hsz = hsz + 64'(tag_len[t]) + 64'd1;
      end
      ccnt = $urandom_range(0, 7);
      slack = $urandom_range(0, 2);
      blen = 64'd8 + hsz + 64'(ccnt) + 64'(slack);

      put_byte(ID_ANIM, 1'b0);
      if (flawed && flaw == FLAW_SHORT_BLOCK)
        put_le(blen - 64'($urandom_range(1, 32'(blen))), 8);
      else put_le(blen, 8);
      put_le(rand64(), 8);
      put_text("CIFF");
      if (flawed && flaw == FLAW_HSIZE) put_le(64'($urandom_range(0, 36)), 8);
      else put_le(hsz, 8);
      put_le(64'(ccnt), 8);
      put_le(rand64(), 8);
      put_le(rand64(), 8);
      for (int c = 0; c <= caplen; c++) begin
        do ch = 8'($urandom); while (ch == CHAR_NL);
        if (c == caplen && !(flawed && flaw == FLAW_NO_NL)) ch = CHAR_NL;
        put_byte(ch, 1'b0);
      end
      for (int t = 0; t < ntag; t++) begin
        repeat (tag_len[t]) put_byte(8'($urandom_range(1, 255)), 1'b0);
        if (flawed && flaw == FLAW_TAG_OPEN && t == ntag - 1)
          put_byte(8'($urandom_range(1, 255)), 1'b0);
        else put_byte(CHAR_NUL, 1'b0);
      end
      repeat (ccnt) put_byte(8'($urandom), 1'b0);
      repeat (slack) put_byte(8'($urandom), 1'b0);
    end

    // bytes past the end of the file
    repeat ($urandom_range(0, 2)) put_byte(8'($urandom), 1'b0);

    if (flaw == FLAW_MUTATE) begin
      idx = $urandom_range(start, stim_q.size() - 1);
      it = stim_q[idx];
      it.b = 8'($urandom);
      stim_q[idx] = it;
    end else if (flaw == FLAW_TRUNCATE) begin
      idx = $urandom_range(start + 1, stim_q.size() - 1);
      while (stim_q.size() > idx) void'(stim_q.pop_back());
    end
  endtask

  initial begin : stimulus
    int dir_n;
    int n;
    int gap_pct;
    int w;

    // bad ids, dead state, restart, extreme field values, magic errors
    add_row(8'h00,      1'b1, 1'b1, rec(KIND_ERROR, {60'd0, ERR_HDR_ID}));
    add_row(ID_HEADER,  1'b0, 1'b1, NO_REC);
    add_row(8'hFF,      1'b1, 1'b1, rec(KIND_ERROR, {60'd0, ERR_HDR_ID}));
    add_row(ID_HEADER,  1'b1, 1'b1, NO_REC);
    add_row(8'hFF,      1'b0, 1'b1, NO_REC);
    add_row(8'hFF,      1'b0, 1'b1, NO_REC);
    add_row(8'hFF,      1'b0, 1'b1, NO_REC);
    add_row(8'hFF,      1'b0, 1'b1, NO_REC);
    add_row(8'hFF,      1'b0, 1'b1, NO_REC);
    add_row(8'hFF,      1'b0, 1'b1, NO_REC);
    add_row(8'hFF,      1'b0, 1'b1, NO_REC);
    add_row(8'hFF,      1'b0, 1'b1, rec(KIND_HDR_LEN, '1));
    add_row("C",        1'b0, 1'b1, NO_REC);
    add_row("A",        1'b0, 1'b1, NO_REC);
    add_row("F",        1'b0, 1'b1, NO_REC);
    add_row("G",        1'b0, 1'b1, rec(KIND_ERROR, {60'd0, ERR_CAFF_MAGIC}));
    add_row(ID_HEADER,  1'b1, 1'b1, NO_REC);
    add_row(8'h01,      1'b0, 1'b0, NO_REC);
    add_row(8'h23,      1'b0, 1'b0, NO_REC);
    add_row(8'h45,      1'b0, 1'b0, NO_REC);
    add_row(8'h67,      1'b0, 1'b0, NO_REC);
    add_row(8'h89,      1'b0, 1'b0, NO_REC);
    add_row(8'hAB,      1'b0, 1'b0, NO_REC);
    add_row(8'hCD,      1'b0, 1'b0, NO_REC);
    add_row(8'hEF,      1'b0, 1'b0, NO_REC);
    add_row("X",        1'b0, 1'b0, NO_REC);
    dir_n = stim_q.size();

    while (stim_q.size() < dir_n + RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom), 1'($urandom_range(0, 1)));
      add_container();
    end
    n = stim_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < n; i++) begin
      if (i < n / 3) begin
        gap_pct = 21;
        rx_idle_pct <= 68;
      end else if (i < 2 * n / 3) begin
        gap_pct = 68;
        rx_idle_pct <= 21;
      end else begin
        gap_pct = 0;
        rx_idle_pct <= 0;
      end
      while ($urandom_range(0, 99) < gap_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= stim_q[i].b;
      s_axis_tuser <= stim_q[i].sof;
      cur_item <= stim_q[i];
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for the byte and record registers
    for (w = 0; w < 4000 && rec_q.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (rec_q.size() != 0) begin
      report_bad("record never produced", rec_q[0], NO_REC);
      fail_cnt += rec_q.size() - 1;
    end

    $display("Sent %0d bytes (%0d directed) over %0d file starts; checked %0d records",
             bytes_taken, dir_n, files_seen, recs_checked);
    $display("  including %0d errors, %0d file completions, %0d pixels; %0d failures",
             err_recs, end_recs, pixel_recs, fail_cnt);
    if (fail_cnt == 0) begin
      $display("animated_image_container_parser_top regression: pass");
    end else begin
      $display("animated_image_container_parser_top regression: fail");
    end
    $finish;
  end

endmodule
